@@ rtl/core/efrc_pkg.sv @@
// Shared types, constants and the byte-wide CRC-32 step for the frame
// receive checker. No dependencies.
`default_nettype none

package efrc_pkg;

  localparam logic [10:0] COUNT_MAX       = 11'd2047;
  localparam logic [10:0] HEADER_OVERHEAD = 11'd18;
  localparam logic [10:0] CRC_START_POS   = 11'd4;
  localparam logic [10:0] DST_END_POS     = 11'd6;
  localparam logic [10:0] SRC_END_POS     = 11'd12;
  localparam logic [10:0] TYPE_END_POS    = 11'd14;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_XOR  = 32'hFFFFFFFF;

  localparam logic [47:0] STATION_RST = 48'h010203040506;
  localparam logic [10:0] MIN_LEN_RST = 11'd64;
  localparam logic [10:0] MAX_LEN_RST = 11'd1518;

  // APB map: 64-bit registers at 8-byte spacing
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;
  localparam logic [1:0] REG_STATION = 2'd0;
  localparam logic [1:0] REG_MIN_LEN = 2'd1;
  localparam logic [1:0] REG_MAX_LEN = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } efrc_byte_t;

  typedef struct packed {
    logic        length_error;
    logic        address_match;
    logic        fcs_match;
    logic [10:0] frame_length;
    logic [10:0] payload_length;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [31:0] received_fcs;
    logic [31:0] computed_fcs;
  } efrc_status_t;

  typedef struct packed {
    logic [47:0] station_address;
    logic [10:0] min_frame_length;
    logic [10:0] max_frame_length;
  } efrc_cfg_t;

  // Frame state frozen at the last byte
  typedef struct packed {
    logic [10:0] frame_length;
    logic [31:0] crc;
    logic [31:0] received_fcs;
    logic [47:0] destination;
    logic [47:0] source;
    logic [15:0] ptype;
  } efrc_snap_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/efrc_if.sv @@
// Valid/ready channel interfaces for frame byte beats and status beats.
// Depends on efrc_pkg.
`default_nettype none

interface efrc_byte_if;
  logic                valid;
  logic                ready;
  efrc_pkg::efrc_byte_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface efrc_status_if;
  logic                  valid;
  logic                  ready;
  efrc_pkg::efrc_status_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ethernet_frame_receive_check_core.sv @@
// Top level of the Ethernet frame receive checker: APB registers, byte
// parser and status queue. Depends on efrc_pkg, efrc_if and the efrc_* modules.
//
//  channel   dir  beat contents                               handshake
//  frame     in   byte_value, last_byte                       valid/ready
//  status    out  one status per frame (see efrc_status_t)    valid/ready
//  apb       in   station_address, min/max_frame_length       psel/penable
//
// Cycles: one byte is taken every cycle frame.ready is high; the header capture,
//   delay line and CRC-32 step all complete in the cycle the byte is accepted.
// The status beat for a frame passes through the snapshot register and then
//   the four-entry status queue before it is offered.
// Stalls: frame.ready drops only when the status queue plus the snapshot
//   stage would exceed four beats; with status.ready held high it never drops.
// Reset (rst, synchronous): clears frame state, empties the queue and loads
//   the register defaults. No clearing pass is needed.
`default_nettype none

module ethernet_frame_receive_check_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  efrc_byte_if.sink                        frame,
  efrc_status_if.source                    status,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [efrc_pkg::APB_AW-1:0] paddr,
  input  wire logic [efrc_pkg::APB_DW-1:0] pwdata,
  output logic      [efrc_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  efrc_pkg::efrc_cfg_t  cfg;
  efrc_pkg::efrc_snap_t snap;
  logic                 snap_valid;
  logic                 room;
  logic                 byte_accept;

  // a byte beat lands when the queue has space for its possible status
  assign frame.ready = room;
  assign byte_accept = frame.valid & room;

  efrc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // header capture, FCS delay line, CRC and length count
  efrc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (byte_accept),
    .in_byte    (frame.data),
    .snap       (snap),
    .snap_valid (snap_valid)
  );

  // length/address/FCS checks and the output buffer
  efrc_status_q u_status_q (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap       (snap),
    .snap_valid (snap_valid),
    .room       (room),
    .status     (status)
  );

endmodule

`default_nettype wire

@@ rtl/core/efrc_regs.sv @@
// APB register file: station address and frame length bounds.
// Depends on efrc_pkg.
`default_nettype none

module efrc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [efrc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [efrc_pkg::APB_DW-1:0]   pwdata,
  output logic      [efrc_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output efrc_pkg::efrc_cfg_t                cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:3];
  assign wr_en     = psel & penable & pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address  <= efrc_pkg::STATION_RST;
      cfg.min_frame_length <= efrc_pkg::MIN_LEN_RST;
      cfg.max_frame_length <= efrc_pkg::MAX_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_index)
        efrc_pkg::REG_STATION: cfg.station_address  <= pwdata[47:0];
        efrc_pkg::REG_MIN_LEN: cfg.min_frame_length <= pwdata[10:0];
        efrc_pkg::REG_MAX_LEN: cfg.max_frame_length <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      efrc_pkg::REG_STATION: prdata = {16'd0, cfg.station_address};
      efrc_pkg::REG_MIN_LEN: prdata = {53'd0, cfg.min_frame_length};
      efrc_pkg::REG_MAX_LEN: prdata = {53'd0, cfg.max_frame_length};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/efrc_parse.sv @@
// Per-byte frame state: header capture, FCS delay line, CRC-32 and length
// count; freezes the frame into a snapshot on the last byte. Uses efrc_pkg.
`default_nettype none

module efrc_parse (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire efrc_pkg::efrc_byte_t in_byte,
  output efrc_pkg::efrc_snap_t      snap,
  output logic                      snap_valid
);

  logic [10:0] byte_count, byte_count_next;
  logic [31:0] crc, crc_next;
  logic [7:0]  tail [4];
  logic [7:0]  tail_next [4];
  logic [47:0] dest, dest_next;
  logic [47:0] src, src_next;
  logic [15:0] ptype, ptype_next;
  logic [7:0]  b;

  assign b = in_byte.byte_value;

  always_comb begin
    dest_next  = dest;
    src_next   = src;
    ptype_next = ptype;
    if (byte_count < efrc_pkg::DST_END_POS) begin
      dest_next = {dest[39:0], b};
    end else if (byte_count < efrc_pkg::SRC_END_POS) begin
      src_next = {src[39:0], b};
    end else if (byte_count < efrc_pkg::TYPE_END_POS) begin
      ptype_next = {ptype[7:0], b};
    end
    // byte leaving the delay line goes into the CRC
    crc_next = (byte_count >= efrc_pkg::CRC_START_POS) ?
               efrc_pkg::crc_byte(crc, tail[0]) : crc;
    tail_next[0] = tail[1];
    tail_next[1] = tail[2];
    tail_next[2] = tail[3];
    tail_next[3] = b;
    byte_count_next = (byte_count < efrc_pkg::COUNT_MAX) ?
                      byte_count + 11'd1 : byte_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc        <= efrc_pkg::CRC_INIT;
      tail       <= '{default: 8'd0};
      dest       <= '0;
      src        <= '0;
      ptype      <= '0;
    end else if (accept) begin
      if (in_byte.last_byte) begin
        byte_count <= '0;
        crc        <= efrc_pkg::CRC_INIT;
        tail       <= '{default: 8'd0};
        dest       <= '0;
        src        <= '0;
        ptype      <= '0;
      end else begin
        byte_count <= byte_count_next;
        crc        <= crc_next;
        tail       <= tail_next;
        dest       <= dest_next;
        src        <= src_next;
        ptype      <= ptype_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= accept & in_byte.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_byte.last_byte) begin
      snap.frame_length <= byte_count_next;
      snap.crc          <= crc_next;
      snap.received_fcs <= {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};
      snap.destination  <= dest_next;
      snap.source       <= src_next;
      snap.ptype        <= ptype_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/efrc_status_q.sv @@
// Builds the status beat from a frame snapshot and the bounds, and queues it
// in a four-entry buffer towards the status channel. Uses efrc_pkg, efrc_if.
`default_nettype none

module efrc_status_q (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire efrc_pkg::efrc_cfg_t  cfg,
  input  wire efrc_pkg::efrc_snap_t snap,
  input  wire logic                 snap_valid,
  output logic                      room,
  efrc_status_if.source             status
);

  efrc_pkg::efrc_status_t res;
  efrc_pkg::efrc_status_t q_mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic [31:0] calc;
  logic        len_bad;
  logic        pop;

  assign calc    = snap.crc ^ efrc_pkg::CRC_XOR;
  assign len_bad = (snap.frame_length < cfg.min_frame_length) ||
                   (snap.frame_length > cfg.max_frame_length);

  always_comb begin
    res = '0;
    if (len_bad) begin
      res.length_error = 1'b1;
    end else begin
      res.address_match  = (snap.destination == cfg.station_address);
      res.fcs_match      = (calc == snap.received_fcs);
      res.frame_length   = snap.frame_length;
      res.payload_length = (snap.frame_length >= efrc_pkg::HEADER_OVERHEAD) ?
                           snap.frame_length - efrc_pkg::HEADER_OVERHEAD : 11'd0;
      res.dst_mac        = snap.destination;
      res.src_mac        = snap.source;
      res.ether_type     = snap.ptype;
      res.received_fcs   = snap.received_fcs;
      res.computed_fcs   = calc;
    end
  end

  // one beat may be in the snapshot stage, so leave space for it
  assign room = (count + {2'd0, snap_valid}) < 3'd4;
  assign pop  = status.valid & status.ready;

  assign status.valid = (count != 3'd0);
  assign status.data  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (snap_valid) wr_ptr <= wr_ptr + 2'd1;
      if (pop)        rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'd0, snap_valid} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid) q_mem[wr_ptr] <= res;
  end

endmodule

`default_nettype wire

@@ rtl/core/efrc_checker.sv @@
// Port-level checks on the frame receive checker, bound to the top level.
// Depends on efrc_pkg and ethernet_frame_receive_check_core.
`default_nettype none

module efrc_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   st_valid,
  input wire logic                   st_ready,
  input wire efrc_pkg::efrc_status_t st_data,
  input wire logic                   pready
);

  // a stalled status beat holds
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    st_valid && !st_ready |=> st_valid && $stable(st_data))
    else $error("status beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !st_valid)
    else $error("status valid after reset");

  a_len_err_clean: assert property (@(posedge clk) disable iff (rst)
    st_valid && st_data.length_error |->
      st_data.frame_length == 11'd0 && !st_data.address_match &&
      !st_data.fcs_match && st_data.computed_fcs == 32'd0)
    else $error("length error beat carries fields");

  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    st_valid && !st_data.length_error |->
      st_data.payload_length == ((st_data.frame_length >= efrc_pkg::HEADER_OVERHEAD) ?
        st_data.frame_length - efrc_pkg::HEADER_OVERHEAD : 11'd0))
    else $error("payload length inconsistent with frame length");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind ethernet_frame_receive_check_core efrc_checker u_efrc_checker (
  .clk      (clk),
  .rst      (rst),
  .st_valid (status.valid),
  .st_ready (status.ready),
  .st_data  (status.data),
  .pready   (pready)
);

`default_nettype wire
